[sv/particle_size_over_lifetime_assert.svh]
// Assertion macros used by the checker module of the particle size block.
`ifndef PARTICLE_SIZE_OVER_LIFETIME_ASSERT_SVH
`define PARTICLE_SIZE_OVER_LIFETIME_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSOL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/psol_pkg.sv]
package psol_pkg;

  localparam int NumAxes  = 3;
  localparam int SizeW    = 24;
  localparam int TimeW    = 32;
  localparam int FracW    = 17;
  localparam int DivSteps = 16;
  localparam int CfgIdxW  = 3;

  localparam logic [FracW-1:0] OneQ16  = 17'h10000;
  localparam logic [FracW-1:0] HalfQ16 = 17'h08000;

  typedef enum logic [1:0] {
    ModeOff     = 2'd0,
    ModeUniform = 2'd1,
    ModePerAxis = 2'd2
  } size_mode_e;

  typedef enum logic [2:0] {
    CurveLinear    = 3'd0,
    CurveEaseIn    = 3'd1,
    CurveEaseOut   = 3'd2,
    CurveEaseInOut = 3'd3,
    CurveConst     = 3'd4
  } curve_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegSizeMode    = 3'd0,
    RegCurveSelect = 3'd1,
    RegEndScalar   = 3'd2,
    RegEndX        = 3'd3,
    RegEndY        = 3'd4,
    RegEndZ        = 3'd5,
    RegSizeFloor   = 3'd6,
    RegSizeCeiling = 3'd7
  } cfg_reg_e;

  typedef logic signed [SizeW-1:0] size_t;

  // One entry per axis; lanes are treated as signed where used.
  typedef logic [NumAxes-1:0][SizeW-1:0] axes_t;
  typedef logic [NumAxes-1:0][SizeW:0]   diffs_t;

  typedef struct packed {
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] lifespan;
    size_t            start_x;
    size_t            start_y;
    size_t            start_z;
  } psol_in_t;

  typedef struct packed {
    logic  updated;
    size_t scale_x;
    size_t scale_y;
    size_t scale_z;
  } psol_out_t;

endpackage

[sv/psol_div.sv]
module psol_div import psol_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [TimeW-1:0] elapsed_i,
  input  logic [TimeW-1:0] lifespan_i,
  input  axes_t            start_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [FracW-1:0] ratio_o,
  output axes_t            start_o
);

  // Stage 0 registers the operands, stages 1..DivSteps each resolve one
  // quotient bit of (elapsed << 16) / lifespan by restoring division.
  logic [DivSteps:0]   vld_q;
  logic [DivSteps:0]   rdy;
  logic [DivSteps:0]   sat_q;
  logic [TimeW-1:0]    rem_q   [DivSteps+1];
  logic [TimeW-1:0]    dvs_q   [DivSteps+1];
  logic [DivSteps-1:0] quo_q   [DivSteps+1];
  axes_t               start_q [DivSteps+1];

  assign rdy[DivSteps] = !vld_q[DivSteps] || ready_i;
  assign rdy[0]        = !vld_q[0] || rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= valid_i;
    end
  end

  // A zero lifetime or an elapsed time at or past the lifetime saturates to 1.0.
  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      rem_q[0]   <= elapsed_i;
      dvs_q[0]   <= lifespan_i;
      quo_q[0]   <= '0;
      sat_q[0]   <= (lifespan_i == '0) || (elapsed_i >= lifespan_i);
      start_q[0] <= start_i;
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [TimeW:0] rem2;
    logic [TimeW:0] sub;
    logic           ge;

    if (k < DivSteps) begin : g_rdy
      assign rdy[k] = !vld_q[k] || rdy[k+1];
    end

    assign rem2 = {rem_q[k-1], 1'b0};
    assign sub  = rem2 - {1'b0, dvs_q[k-1]};
    assign ge   = !sub[TimeW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_q[k-1]) begin
        rem_q[k]   <= ge ? sub[TimeW-1:0] : rem2[TimeW-1:0];
        dvs_q[k]   <= dvs_q[k-1];
        quo_q[k]   <= {quo_q[k-1][DivSteps-2:0], ge};
        sat_q[k]   <= sat_q[k-1];
        start_q[k] <= start_q[k-1];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[DivSteps];
  assign ratio_o = sat_q[DivSteps] ? OneQ16
                                   : {{(FracW-DivSteps){1'b0}}, quo_q[DivSteps]};
  assign start_o = start_q[DivSteps];

endmodule

[sv/psol_shape.sv]
module psol_shape import psol_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [FracW-1:0] ratio_i,
  input  axes_t            start_i,
  input  axes_t            end_i,
  input  logic [2:0]       curve_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [FracW-1:0] coef_o,
  output axes_t            start_o,
  output diffs_t           diff_o
);

  logic               rdy_a, rdy_b;
  logic               a_vld_q, b_vld_q;
  logic [FracW-1:0]   rem_t, sq_op;
  logic [2*FracW-1:0] sq_d, a_sq_q;
  logic [FracW-1:0]   a_t_q;
  axes_t              a_start_q, b_start_q;
  diffs_t             diff_d, a_diff_q, b_diff_q;
  logic [FracW-1:0]   sh16, sh15, coef_d, b_coef_q;
  logic               use_t;

  assign rdy_b   = !b_vld_q || ready_i;
  assign rdy_a   = !a_vld_q || rdy_b;
  assign ready_o = rdy_a;

  // Stage A: square of t or of (1 - t), and the end-minus-start distances.
  assign rem_t = OneQ16 - ratio_i;
  assign use_t = (curve_i == CurveEaseIn) ||
                 ((curve_i == CurveEaseInOut) && (ratio_i < HalfQ16));
  assign sq_op = use_t ? ratio_i : rem_t;
  assign sq_d  = sq_op * sq_op;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      diff_d[a] = {end_i[a][SizeW-1], end_i[a]} - {start_i[a][SizeW-1], start_i[a]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_vld_q <= valid_i;
      end
      if (rdy_b) begin
        b_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      a_sq_q    <= sq_d;
      a_t_q     <= ratio_i;
      a_start_q <= start_i;
      a_diff_q  <= diff_d;
    end
  end

  // Stage B: the square scaled by two or by one, folded per curve.
  assign sh16 = a_sq_q[FracW+15:16];
  assign sh15 = a_sq_q[FracW+14:15];

  always_comb begin
    case (curve_i)
      CurveLinear:    coef_d = a_t_q;
      CurveEaseIn:    coef_d = sh16;
      CurveEaseOut:   coef_d = OneQ16 - sh16;
      CurveEaseInOut: coef_d = (a_t_q < HalfQ16) ? sh15 : OneQ16 - sh15;
      CurveConst:     coef_d = '0;
      default:        coef_d = a_t_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_vld_q) begin
      b_coef_q  <= coef_d;
      b_start_q <= a_start_q;
      b_diff_q  <= a_diff_q;
    end
  end

  assign valid_o = b_vld_q;
  assign coef_o  = b_coef_q;
  assign start_o = b_start_q;
  assign diff_o  = b_diff_q;

endmodule

[sv/psol_lerp.sv]
module psol_lerp import psol_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [FracW-1:0] coef_i,
  input  axes_t            start_i,
  input  diffs_t           diff_i,
  input  size_t            floor_i,
  input  size_t            ceil_i,
  input  logic             upd_i,
  output logic             valid_o,
  input  logic             ready_i,
  output psol_out_t        data_o
);

  localparam int ProdW = SizeW + 1 + FracW + 1;
  localparam int SumW  = ProdW - 16;

  logic                    rdy_p, rdy_o;
  logic                    p_vld_q, o_vld_q;
  logic signed [ProdW-1:0] prod_d [NumAxes];
  logic signed [ProdW-1:0] prod_q [NumAxes];
  axes_t                   p_start_q;
  logic signed [SumW-1:0]  sum_v  [NumAxes];
  logic signed [SumW-1:0]  lo, hi;
  axes_t                   res;
  psol_out_t               out_d, o_data_q;

  assign rdy_o   = !o_vld_q || ready_i;
  assign rdy_p   = !p_vld_q || rdy_o;
  assign ready_o = rdy_p;

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      prod_d[a] = $signed(diff_i[a]) * $signed({1'b0, coef_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (rdy_p) begin
        p_vld_q <= valid_i;
      end
      if (rdy_o) begin
        o_vld_q <= p_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p && valid_i) begin
      prod_q    <= prod_d;
      p_start_q <= start_i;
    end
  end

  // The arithmetic shift of the product rounds toward minus infinity.
  assign lo = $signed({{(SumW-SizeW){floor_i[SizeW-1]}}, floor_i});
  assign hi = $signed({{(SumW-SizeW){ceil_i[SizeW-1]}}, ceil_i});

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      sum_v[a] = $signed({{(SumW-SizeW){p_start_q[a][SizeW-1]}}, p_start_q[a]})
               + $signed(prod_q[a][ProdW-1:16]);
      if (sum_v[a] < lo) begin
        res[a] = floor_i;
      end else if (sum_v[a] > hi) begin
        res[a] = ceil_i;
      end else begin
        res[a] = sum_v[a][SizeW-1:0];
      end
    end
  end

  always_comb begin
    out_d = '0;
    if (upd_i) begin
      out_d.updated = 1'b1;
      out_d.scale_x = res[0];
      out_d.scale_y = res[1];
      out_d.scale_z = res[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && p_vld_q) begin
      o_data_q <= out_d;
    end
  end

  assign valid_o = o_vld_q;
  assign data_o  = o_data_q;

endmodule

[sv/particle_size_over_lifetime.sv]
// Particle size over lifetime. Each input transaction carries one particle
// (elapsed time, lifetime and start scale) and yields exactly one output
// transaction with the new scale, in arrival order. The block accepts one
// particle per clock cycle while its input is not stalled, and passes it
// through one input register, sixteen divider stages that each resolve one
// bit of the lifetime ratio, two stages that square and shape the ratio, and
// two stages that multiply, add and clamp. The one-bit-per-stage divider sets
// that depth. An output stall holds only the stages that are full, so empty
// stages keep taking new particles. Configuration registers are read live
// by the datapath and must only be written while no transaction is in flight.
module particle_size_over_lifetime import psol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  psol_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output psol_out_t          out_data_o
);

  // Configuration registers.
  logic [1:0]       size_mode_q;
  logic [2:0]       curve_sel_q;
  logic [SizeW-1:0] end_scalar_q, end_x_q, end_y_q, end_z_q;
  logic [SizeW-1:0] size_floor_q, size_ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_mode_q  <= ModeUniform;
      curve_sel_q  <= CurveLinear;
      end_scalar_q <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      end_z_q      <= '0;
      size_floor_q <= '0;
      size_ceil_q  <= 24'd6553600;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSizeMode:    size_mode_q  <= cfg_data_i[1:0];
        RegCurveSelect: curve_sel_q  <= cfg_data_i[2:0];
        RegEndScalar:   end_scalar_q <= cfg_data_i;
        RegEndX:        end_x_q      <= cfg_data_i;
        RegEndY:        end_y_q      <= cfg_data_i;
        RegEndZ:        end_z_q      <= cfg_data_i;
        RegSizeFloor:   size_floor_q <= cfg_data_i;
        RegSizeCeiling: size_ceil_q  <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // In uniform mode all three lanes carry start x against the scalar end size,
  // so they produce the same value. Modes other than uniform and per-axis
  // still flow through the pipeline but come out as zero with no update.
  logic  uniform, upd;
  axes_t lane_start, lane_end;

  assign uniform = (size_mode_q == ModeUniform);
  assign upd     = uniform || (size_mode_q == ModePerAxis);

  assign lane_start[0] = in_data_i.start_x;
  assign lane_start[1] = uniform ? in_data_i.start_x : in_data_i.start_y;
  assign lane_start[2] = uniform ? in_data_i.start_x : in_data_i.start_z;
  assign lane_end[0]   = uniform ? end_scalar_q : end_x_q;
  assign lane_end[1]   = uniform ? end_scalar_q : end_y_q;
  assign lane_end[2]   = uniform ? end_scalar_q : end_z_q;

  // Ratio of elapsed time to lifetime, Q1.16 clamped to 0..1.
  logic             div_ready, div_valid;
  logic [FracW-1:0] ratio;
  axes_t            div_start;

  // The user must keep the end sizes stable for the life of a transaction;
  // the block does not enforce it. The shaper reads them live from the config.
  logic             shp_ready, shp_valid;
  logic [FracW-1:0] coef;
  axes_t            shp_start;
  diffs_t           shp_diff;

  logic             lrp_ready;

  psol_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (div_ready),
    .elapsed_i  (in_data_i.elapsed),
    .lifespan_i (in_data_i.lifespan),
    .start_i    (lane_start),
    .valid_o    (div_valid),
    .ready_i    (shp_ready),
    .ratio_o    (ratio),
    .start_o    (div_start)
  );

  psol_shape u_shape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (shp_ready),
    .ratio_i (ratio),
    .start_i (div_start),
    .end_i   (lane_end),
    .curve_i (curve_sel_q),
    .valid_o (shp_valid),
    .ready_i (lrp_ready),
    .coef_o  (coef),
    .start_o (shp_start),
    .diff_o  (shp_diff)
  );

  psol_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (shp_valid),
    .ready_o (lrp_ready),
    .coef_i  (coef),
    .start_i (shp_start),
    .diff_i  (shp_diff),
    .floor_i (size_floor_q),
    .ceil_i  (size_ceil_q),
    .upd_i   (upd),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .data_o  (out_data_o)
  );

  assign in_stall_o = !div_ready;

endmodule

[sv/psol_checker.sv]
`include "particle_size_over_lifetime_assert.svh"

module psol_checker import psol_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input psol_out_t          out_data_o
);

  // A stalled result stays in place until it is taken.
  `PSOL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output transaction changed")

  // The input side can only be held back when every stage is full and the
  // output is stalled.
  `PSOL_ASSERT_NOW(a_stall_source, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a stalled output")

  // A particle that was not updated carries a zero scale on every axis.
  `PSOL_ASSERT_NOW(a_off_zero, clk_i, rst_ni, out_valid_o && !out_data_o.updated, (out_data_o.scale_x == '0) && (out_data_o.scale_y == '0) && (out_data_o.scale_z == '0), "scale not zero when not updated")

endmodule

bind particle_size_over_lifetime psol_checker u_psol_checker (.*);
